// ----- rtl/nvt_pkg.sv -----
`default_nettype none

package nvt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    localparam int MODE_W = 2;
    localparam int ROW_W  = 8;
    localparam int VOLT_W = 12;
    localparam int TEMP_W = 9;
    localparam int VIN_W  = 16;
    localparam int LEN_W  = 9;
    localparam int RES_W  = 19;

    localparam int VPOS_W = 15;
    localparam int X_W    = 22;
    localparam int DIV_W  = 22;
    localparam int MUL_AW = 21;
    localparam int MUL_BW = 11;
    localparam int MUL_PW = 32;
    localparam int MAG_W  = 19;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 1;

    localparam int VOLT_DEFAULT = 2457;
    localparam int MILLI        = 1000;
    localparam int LEN_MIN      = 2;
    localparam int LEN_RESET    = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRECISE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COARSE  = 2'd2;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [VOLT_W-1:0]        coarse;
        logic [VOLT_W-1:0]        precise;
    } row_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_ISSUE,
        S_P_FIRST,
        S_P_LAST,
        S_P_SCAN,
        S_C_ISSUE,
        S_C_SCAN,
        S_T_MUL,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIV1_GO,
        S_DIV1,
        S_Q_MUL,
        S_R_MUL,
        S_DIV2_GO,
        S_DIV2,
        S_FIN,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/nvt_ram.sv -----
`default_nettype none

module nvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/nvt_div.sv -----
`default_nettype none

module nvt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [nvt_pkg::DIV_W-1:0]   dividend,
    input  wire logic [nvt_pkg::VOLT_W-1:0]  divisor,
    output logic                             done,
    output logic      [nvt_pkg::DIV_W-1:0]   quotient,
    output logic      [nvt_pkg::VOLT_W-1:0]  remainder
);

    import nvt_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [VOLT_W-1:0] rem_reg;

    logic [VOLT_W:0]   rem_shift;
    logic [VOLT_W:0]   rem_sub;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[VOLT_W-1:0] : rem_shift[VOLT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/ntc_voltage_to_temperature.sv -----
`default_nettype none

// Thermistor voltage to temperature converter. Load items (tuser mode 0) write
// one table row (precise voltage, coarse voltage, temperature) and give no
// result. A precise convert (mode 1) reads row 0 and the last row in use to
// clamp, then scans the table one row per cycle from row 1 until the bracket is
// found, interpolates with a shared 21x11 multiplier and two serial divisions of
// a 22-bit dividend, and returns millidegrees; the table scan goes through the
// single read port of the row memory. A coarse convert (mode 2) scans down from
// the last row. Mode 3 is taken and dropped. Non-positive voltages are replaced
// by 2457 mV. Rows in use must be loaded before a convert reads them; the user
// must write table_length through cfg_wr_en/cfg_wr_data only while the block is
// idle, as the block itself does not enforce this.

module ntc_voltage_to_temperature #(
    parameter int TABLE_DEPTH = nvt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [nvt_pkg::LEN_W-1:0]         cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // row_index[7:0], precise_volt_entry[19:8], coarse_volt_entry[31:20],
    // temp_entry[40:32], voltage_mv[56:41]
    input  wire logic [nvt_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  wire logic [nvt_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // temperature[18:0]
    output logic      [nvt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // in_millidegrees[0]
    output logic      [nvt_pkg::OUT_USER_W-1:0]    m_tuser
);

    import nvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $bits(row_t);
    localparam logic signed [MUL_BW-1:0] MILLI_B = MUL_BW'(MILLI);

    state_t state_reg, state_next;
    logic [LEN_W-1:0]  table_length_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [VPOS_W-1:0] v_reg, v_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     idx_reg, idx_next;
    row_t              prev_reg, prev_next;
    row_t              cur_reg, cur_next;
    logic [VOLT_W-1:0] d_reg, d_next;
    logic signed [X_W-1:0]    x_reg, x_next;
    logic signed [MUL_PW-1:0] prod_reg, prod_next;
    logic              neg_reg, neg_next;
    logic [MAG_W-1:0]  acc_reg, acc_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              milli_reg, milli_next;
    logic [RES_W-1:0]  m_temp_reg;
    logic              m_milli_reg;

    logic [MODE_W-1:0]        in_mode;
    logic [ROW_W-1:0]         in_row;
    logic [VOLT_W-1:0]        in_prec;
    logic [VOLT_W-1:0]        in_coarse;
    logic signed [TEMP_W-1:0] in_temp;
    logic signed [VIN_W-1:0]  in_volt;
    logic [VPOS_W-1:0]        in_vpos;
    logic [AW-1:0]            len_last;
    logic                     accept;
    logic                     out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    row_t              ram_wrow;
    logic [AW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;
    row_t              rd_row;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [VOLT_W-1:0] div_rem;
    logic [VOLT_W-1:0] v12;
    logic [MAG_W-1:0]  fin_mag;

    assign in_mode   = s_tuser[1:0];
    assign in_row    = s_tdata[7:0];
    assign in_prec   = s_tdata[19:8];
    assign in_coarse = s_tdata[31:20];
    assign in_temp   = s_tdata[40:32];
    assign in_volt   = s_tdata[56:41];
    assign in_vpos   = (in_volt <= 0) ? VPOS_W'(VOLT_DEFAULT) : in_volt[VPOS_W-1:0];

    assign len_last = (table_length_reg < LEN_W'(LEN_MIN)) ? AW'(1) :
                      (int'(table_length_reg) > TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1) :
                      AW'(table_length_reg - 1'b1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ram_we    = accept && (in_mode == MODE_LOAD) && (int'(in_row) < TABLE_DEPTH);
    assign ram_waddr = AW'(in_row);
    assign ram_wrow  = '{temp: in_temp, coarse: in_coarse, precise: in_prec};
    assign rd_row    = row_t'(ram_rdata);

    nvt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mul_p   = mul_a * mul_b;
    assign v12     = v_reg[VOLT_W-1:0];
    assign fin_mag = acc_reg + div_quo[MAG_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        v_next        = v_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        d_next        = d_reg;
        x_next        = x_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        milli_next    = milli_reg;
        ram_raddr     = '0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_dividend  = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next    = in_vpos;
                    last_next = len_last;
                    if (in_mode == MODE_PRECISE)
                    begin
                        state_next = S_P_ISSUE;
                    end
                    else if (in_mode == MODE_COARSE)
                    begin
                        state_next = S_C_ISSUE;
                    end
                end
            end
            S_P_ISSUE:
            begin
                ram_raddr  = '0;
                state_next = S_P_FIRST;
            end
            S_P_FIRST:
            begin
                ram_raddr = last_reg;
                if (v_reg >= VPOS_W'(rd_row.precise))
                begin
                    cur_next   = rd_row;
                    state_next = S_T_MUL;
                end
                else
                begin
                    prev_next  = rd_row;
                    state_next = S_P_LAST;
                end
            end
            S_P_LAST:
            begin
                ram_raddr = AW'(1);
                idx_next  = AW'(1);
                if (v_reg <= VPOS_W'(rd_row.precise))
                begin
                    cur_next   = rd_row;
                    state_next = S_T_MUL;
                end
                else
                begin
                    state_next = S_P_SCAN;
                end
            end
            S_P_SCAN:
            begin
                ram_raddr = idx_reg + 1'b1;
                if ((v_reg >= VPOS_W'(rd_row.precise)) || (idx_reg == last_reg))
                begin
                    cur_next   = rd_row;
                    state_next = S_MUL1;
                end
                else
                begin
                    prev_next = rd_row;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_C_ISSUE:
            begin
                ram_raddr  = last_reg;
                idx_next   = last_reg;
                state_next = S_C_SCAN;
            end
            S_C_SCAN:
            begin
                ram_raddr = idx_reg - 1'b1;
                if ((idx_reg == '0) || (VPOS_W'(rd_row.coarse) >= v_reg))
                begin
                    res_next   = RES_W'(rd_row.temp);
                    milli_next = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_T_MUL:
            begin
                mul_a      = MUL_AW'(cur_reg.temp);
                mul_b      = MILLI_B;
                res_next   = mul_p[RES_W-1:0];
                milli_next = 1'b1;
                state_next = S_OUT;
            end
            S_MUL1:
            begin
                mul_a      = MUL_AW'(v12 - cur_reg.precise);
                mul_b      = MUL_BW'(prev_reg.temp);
                prod_next  = mul_p;
                d_next     = prev_reg.precise - cur_reg.precise;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_a      = MUL_AW'(prev_reg.precise - v12);
                mul_b      = MUL_BW'(cur_reg.temp);
                x_next     = X_W'(prod_reg);
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                x_next     = x_reg + X_W'(prod_reg);
                state_next = S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                div_start    = 1'b1;
                div_dividend = x_reg[X_W-1] ? DIV_W'(-x_reg) : DIV_W'(x_reg);
                neg_next     = x_reg[X_W-1];
                state_next   = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    state_next = S_Q_MUL;
                end
            end
            S_Q_MUL:
            begin
                mul_a      = MUL_AW'(div_quo);
                mul_b      = MILLI_B;
                prod_next  = mul_p;
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                acc_next   = prod_reg[MAG_W-1:0];
                mul_a      = MUL_AW'(div_rem);
                mul_b      = MILLI_B;
                prod_next  = mul_p;
                state_next = S_DIV2_GO;
            end
            S_DIV2_GO:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg[DIV_W-1:0];
                state_next   = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_next   = neg_reg ? (~fin_mag + 1'b1) : fin_mag;
                milli_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            table_length_reg <= LEN_W'(LEN_RESET);
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                table_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        d_reg     <= d_next;
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
        milli_reg <= milli_next;
        if (out_load)
        begin
            m_temp_reg  <= res_reg;
            m_milli_reg <= milli_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, m_temp_reg};
    assign m_tuser  = m_milli_reg;

endmodule

`default_nettype wire
